// ===== design/kvtl_pkg.sv =====
`default_nettype none
package kvtl_pkg;
  localparam int CntW = 6;

  typedef struct packed {
    logic [63:0] key0;
    logic [63:0] key1;
    logic [23:0] key2;
    logic [63:0] val0;
    logic [63:0] val1;
    logic [23:0] val2;
  } entry_t;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_FIND   = 2'd1,
    CMD_STATUS = 2'd2,
    CMD_DELETE = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    RC_ADDED    = 3'd0,
    RC_FOUND    = 3'd1,
    RC_NOTFOUND = 3'd2,
    RC_DELETED  = 3'd3,
    RC_ENTRY    = 3'd4,
    RC_TOTAL    = 3'd5,
    RC_FULL     = 3'd6
  } code_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_WALK  = 2'd1,
    ST_WALK2 = 2'd2,
    ST_FIN   = 2'd3
  } state_e;
endpackage
`default_nettype wire

// ===== design/kvtl_cell.sv =====
`default_nettype none
// One table slot; loads from its neighbor on shift, from the host on write.
module kvtl_cell (
  input  wire                 clk_i,
  input  wire                 shift_i,
  input  wire                 wr_i,
  input  kvtl_pkg::entry_t    nbr_i,
  input  kvtl_pkg::entry_t    wdata_i,
  output kvtl_pkg::entry_t    data_o
);
  kvtl_pkg::entry_t data_q, data_d;

  always_comb begin
    data_d = data_q;
    if (shift_i) begin
      data_d = nbr_i;
    end else if (wr_i) begin
      data_d = wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
endmodule
`default_nettype wire

// ===== design/key_value_table_linear_core.sv =====
`default_nettype none
// Unsorted key/value table held in a ring of CAPACITY cells. Add answers in
// the next cycle. Find, status and delete rotate the ring one full turn so
// every slot passes the head cell; delete that hits takes a second turn to
// drop the last entry into the matched slot. Find and delete answer after the
// turn (after the second turn on a delete hit); status streams list-entry
// beats during the turn, then the total beat. busy_o is high while a turn
// runs; a new command may start the cycle busy_o drops. Result beats appear
// for one cycle on valid_o and cannot be stalled.
module key_value_table_linear_core #(
  parameter int CAPACITY = 32
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          start_i,
  output logic         busy_o,
  input  wire  [1:0]   cmd_i,
  input  wire  [63:0]  key_word0_i,
  input  wire  [63:0]  key_word1_i,
  input  wire  [23:0]  key_word2_i,
  input  wire  [63:0]  val_word0_i,
  input  wire  [63:0]  val_word1_i,
  input  wire  [23:0]  val_word2_i,
  output logic         valid_o,
  output logic [2:0]   code_o,
  output logic [63:0]  out_key0_o,
  output logic [63:0]  out_key1_o,
  output logic [63:0]  out_val0_o,
  output logic [23:0]  out_key2_o,
  output logic [63:0]  out_val1_o,
  output logic [23:0]  out_val2_o,
  output logic [5:0]   total_o,
  output logic         last_o
);
  localparam int W = kvtl_pkg::CntW;
  localparam logic [W-1:0] LastStep = W'(CAPACITY - 1);
  localparam logic [W-1:0] Cap      = W'(CAPACITY);

  kvtl_pkg::state_e state_q, state_d;
  logic [W-1:0]     cnt_q, cnt_d;
  logic [W-1:0]     step_q, step_d;
  logic [W-1:0]     hit_q, hit_d;
  logic             found_q, found_d;
  kvtl_pkg::cmd_e   cmd_q, cmd_d;
  kvtl_pkg::entry_t req_q, req_d;     // search key, or add data
  kvtl_pkg::entry_t lastent_q, lastent_d;

  logic             rv_q, rv_d;
  kvtl_pkg::code_e  rc_q, rc_d;
  kvtl_pkg::entry_t rent_q, rent_d;
  logic [W-1:0]     rtot_q, rtot_d;
  logic             rlast_q, rlast_d;

  kvtl_pkg::entry_t cells [CAPACITY];
  kvtl_pkg::entry_t tail_in;
  kvtl_pkg::entry_t head;
  kvtl_pkg::entry_t wdata;
  logic             shift;
  logic             replace;
  logic             add_wr;
  logic             accept;
  logic             head_live;
  logic             head_match;

  assign head   = cells[0];
  assign accept = start_i && (state_q == kvtl_pkg::ST_IDLE);
  assign wdata  = '{key0: key_word0_i, key1: key_word1_i, key2: key_word2_i,
                    val0: val_word0_i, val1: val_word1_i, val2: val_word2_i};
  assign add_wr = accept && (kvtl_pkg::cmd_e'(cmd_i) == kvtl_pkg::CMD_ADD) &&
                  (cnt_q < Cap);
  assign shift  = (state_q == kvtl_pkg::ST_WALK) || (state_q == kvtl_pkg::ST_WALK2);
  assign replace = (state_q == kvtl_pkg::ST_WALK2) && (step_q == hit_q);
  assign tail_in = replace ? lastent_q : head;
  assign head_live  = step_q < cnt_q;
  assign head_match = head_live && (head.key0 == req_q.key0) &&
                      (head.key1 == req_q.key1) && (head.key2 == req_q.key2);

  // ring: cell k takes cell k+1, tail takes head (or the moved last entry)
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    kvtl_pkg::entry_t nbr;
    if (i == CAPACITY - 1) begin : g_tail
      assign nbr = tail_in;
    end else begin : g_mid
      assign nbr = cells[i+1];
    end
    kvtl_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (shift),
      .wr_i    (add_wr && (cnt_q == W'(i))),
      .nbr_i   (nbr),
      .wdata_i (wdata),
      .data_o  (cells[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kvtl_pkg::ST_IDLE;
      cnt_q   <= '0;
      step_q  <= '0;
      rv_q    <= 1'b0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      step_q  <= step_d;
      rv_q    <= rv_d;
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q     <= hit_d;
    cmd_q     <= cmd_d;
    req_q     <= req_d;
    lastent_q <= lastent_d;
    rc_q      <= rc_d;
    rent_q    <= rent_d;
    rtot_q    <= rtot_d;
    rlast_q   <= rlast_d;
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    step_d    = step_q;
    hit_d     = hit_q;
    found_d   = found_q;
    cmd_d     = cmd_q;
    req_d     = req_q;
    lastent_d = lastent_q;
    rv_d      = 1'b0;
    rc_d      = rc_q;
    rent_d    = '0;
    rtot_d    = '0;
    rlast_d   = 1'b1;
    case (state_q)
      kvtl_pkg::ST_IDLE: begin
        if (accept) begin
          cmd_d   = kvtl_pkg::cmd_e'(cmd_i);
          req_d   = wdata;
          step_d  = '0;
          found_d = 1'b0;
          if (kvtl_pkg::cmd_e'(cmd_i) == kvtl_pkg::CMD_ADD) begin
            rv_d = 1'b1;
            if (cnt_q < Cap) begin
              rc_d  = kvtl_pkg::RC_ADDED;
              cnt_d = cnt_q + 1'b1;
            end else begin
              rc_d = kvtl_pkg::RC_FULL;
            end
          end else begin
            state_d = kvtl_pkg::ST_WALK;
          end
        end
      end
      kvtl_pkg::ST_WALK: begin
        if (head_match && !found_q) begin
          found_d   = 1'b1;
          hit_d     = step_q;
          rent_d    = '0;
          lastent_d = head;  // holds the hit's value for find
        end
        if (cmd_q == kvtl_pkg::CMD_DELETE && head_live && step_q == cnt_q - 1'b1) begin
          lastent_d = head;
        end
        if (cmd_q == kvtl_pkg::CMD_STATUS && head_live) begin
          rv_d    = 1'b1;
          rc_d    = kvtl_pkg::RC_ENTRY;
          rent_d  = head;
          rlast_d = 1'b0;
        end
        step_d = step_q + 1'b1;
        if (step_q == LastStep) begin
          step_d = '0;
          if (cmd_q == kvtl_pkg::CMD_DELETE && found_d) begin
            state_d = kvtl_pkg::ST_WALK2;
          end else begin
            state_d = kvtl_pkg::ST_FIN;
          end
        end
      end
      kvtl_pkg::ST_WALK2: begin
        step_d = step_q + 1'b1;
        if (step_q == LastStep) begin
          step_d  = '0;
          state_d = kvtl_pkg::ST_FIN;
        end
      end
      kvtl_pkg::ST_FIN: begin
        rv_d    = 1'b1;
        state_d = kvtl_pkg::ST_IDLE;
        case (cmd_q)
          kvtl_pkg::CMD_STATUS: begin
            rc_d   = kvtl_pkg::RC_TOTAL;
            rtot_d = cnt_q;
          end
          kvtl_pkg::CMD_FIND: begin
            if (found_q) begin
              rc_d        = kvtl_pkg::RC_FOUND;
              rent_d.val0 = lastent_q.val0;
              rent_d.val1 = lastent_q.val1;
              rent_d.val2 = lastent_q.val2;
            end else begin
              rc_d = kvtl_pkg::RC_NOTFOUND;
            end
          end
          default: begin
            if (found_q) begin
              rc_d  = kvtl_pkg::RC_DELETED;
              cnt_d = cnt_q - 1'b1;
            end else begin
              rc_d = kvtl_pkg::RC_NOTFOUND;
            end
          end
        endcase
      end
      default: state_d = kvtl_pkg::ST_IDLE;
    endcase
  end

  assign busy_o     = (state_q != kvtl_pkg::ST_IDLE);
  assign valid_o    = rv_q;
  assign code_o     = rc_q;
  assign out_key0_o = rent_q.key0;
  assign out_key1_o = rent_q.key1;
  assign out_key2_o = rent_q.key2;
  assign out_val0_o = rent_q.val0;
  assign out_val1_o = rent_q.val1;
  assign out_val2_o = rent_q.val2;
  assign total_o    = rtot_q;
  assign last_o     = rlast_q;

  a_idle_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == kvtl_pkg::ST_IDLE) |-> (step_q == '0))
    else $error("walk step not home while idle");
  a_cnt_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= Cap)
    else $error("entry count above capacity");
  a_total_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rv_q && rc_q == kvtl_pkg::RC_TOTAL) |-> (rlast_q && rtot_q == cnt_q))
    else $error("total beat malformed");
  a_walk2_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == kvtl_pkg::ST_WALK2) |-> (found_q && cmd_q == kvtl_pkg::CMD_DELETE))
    else $error("second turn without a delete hit");
endmodule
`default_nettype wire
